@@ design/lsh_pkg.sv @@
package lsh_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;

  localparam int PIX_W = 8;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WID_W = COL_W + 1;
  localparam int HGT_W = ROW_W + 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = HGT_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // position and flags of one pixel in flight
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             frame_last;
    logic             emit;
  } pix_meta_t;

  // one result item
  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             frame_end;
  } res_item_t;

  // window stage status towards the top level
  typedef struct packed {
    logic      busy;
    logic      emit;
    res_item_t item;
  } win_res_t;

endpackage

@@ design/lsh_line_store.sv @@
module lsh_line_store (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [lsh_pkg::COL_W-1:0]  rd_addr,
  input  logic                       wr_en,
  input  logic [lsh_pkg::COL_W-1:0]  wr_addr,
  input  logic [lsh_pkg::PIX_W-1:0]  wr_upper,
  input  logic [lsh_pkg::PIX_W-1:0]  wr_middle,
  output logic [lsh_pkg::PIX_W-1:0]  rd_upper,
  output logic [lsh_pkg::PIX_W-1:0]  rd_middle
);
  import lsh_pkg::*;

  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [PIX_W-1:0] upper_q_r;
  logic [PIX_W-1:0] middle_q_r;
  logic             fwd_r;
  logic [PIX_W-1:0] fwd_upper_r;
  logic [PIX_W-1:0] fwd_middle_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

  // read-before-write array; a same-address write on the read edge is bypassed
  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_q_r    <= upper_mem[rd_addr];
      middle_q_r   <= middle_mem[rd_addr];
      fwd_r        <= wr_en && (wr_addr == rd_addr);
      fwd_upper_r  <= wr_upper;
      fwd_middle_r <= wr_middle;
    end
  end

  assign rd_upper  = fwd_r ? fwd_upper_r  : upper_q_r;
  assign rd_middle = fwd_r ? fwd_middle_r : middle_q_r;

endmodule

@@ design/lsh_window.sv @@
module lsh_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift_en,
  input  logic [lsh_pkg::PIX_W-1:0] top_px,
  input  logic [lsh_pkg::PIX_W-1:0] mid_px,
  input  logic [lsh_pkg::PIX_W-1:0] bot_px,
  input  lsh_pkg::pix_meta_t        meta_in,
  output lsh_pkg::win_res_t         res
);
  import lsh_pkg::*;

  localparam int NSUM_W = PIX_W + 3;
  localparam int V_W    = PIX_W + 5;

  // [row 0 top .. 2 bottom][col 0 oldest .. 2 newest]
  logic [PIX_W-1:0] win_r [3][3];
  logic             s2_v_r;
  pix_meta_t        meta_r;

  logic [NSUM_W-1:0] nsum;
  logic [V_W-1:0]    v;
  logic [PIX_W-1:0]  sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      s2_v_r <= shift_en;
      if (shift_en) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i][0] <= win_r[i][1];
          win_r[i][1] <= win_r[i][2];
        end
        win_r[0][2] <= top_px;
        win_r[1][2] <= mid_px;
        win_r[2][2] <= bot_px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      meta_r <= meta_in;
    end
  end

  always_comb begin
    nsum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!(i == 1 && j == 1)) begin
          nsum = nsum + NSUM_W'(win_r[i][j]);
        end
      end
    end
    v = {2'b00, win_r[1][1], 3'b000} - {2'b00, nsum};
    if (v[V_W-1]) begin
      sat = '0;
    end else if (v[V_W-2:PIX_W] != '0) begin
      sat = '1;
    end else begin
      sat = v[PIX_W-1:0];
    end
  end

  assign res.busy           = s2_v_r;
  assign res.emit           = s2_v_r && meta_r.emit;
  assign res.item.out_pixel = sat;
  assign res.item.out_row   = meta_r.row - ROW_W'(1);
  assign res.item.out_col   = meta_r.col - COL_W'(1);
  assign res.item.frame_end = meta_r.frame_last;

endmodule

@@ design/lsh_out_fifo.sv @@
module lsh_out_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  lsh_pkg::res_item_t          push_item,
  input  logic                        pop,
  output logic                        not_empty,
  output lsh_pkg::res_item_t          head,
  output logic [lsh_pkg::FIFO_CW-1:0] level
);
  import lsh_pkg::*;

  res_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r;
  logic [FIFO_AW-1:0] rp_r;
  logic [FIFO_CW-1:0] cnt_r;
  logic               do_pop;

  assign not_empty = (cnt_r != '0);
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rp_r];
  assign level     = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + FIFO_AW'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_r + FIFO_CW'(push) - FIFO_CW'(do_pop);
    end
  end

endmodule

@@ design/laplacian_sharpen_3x3.sv @@
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    tdata: pixel; tuser: frame_start
// out_     out  out_tvalid/out_tready  tdata: out_pixel,out_row,out_col; tlast: frame_end
// cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data (cfg_ready always high)
//
// One pixel per clock sustained while the output is not stalled. Each accepted
// pixel passes through the line-store read, the window update and the write of
// its result into the output queue. Reset (rst_n low, synchronous) clears the
// counters, window, pipeline valids and queue and loads width 640 / height 480;
// line stores are not cleared. A stalled output fills a four-entry queue;
// in_tready drops once queued plus in-flight results would reach its depth.
module laplacian_sharpen_3x3 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] pixel
  input  logic                           in_tuser,   // [0] frame_start
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // [7:0] out_pixel, [19:8] out_row,
                                                     // [30:20] out_col, [31] zero
  output logic                           out_tlast,  // frame_end
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lsh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lsh_pkg::*;

  // configuration
  logic [WID_W-1:0] image_width_r;
  logic [HGT_W-1:0] image_height_r;
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;

  // raster position
  logic [COL_W-1:0] col_count_r, col_count_nxt;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic             row_end;
  logic             frame_last;

  // stage 1: line-store read data valid
  logic             s1_v_r;
  logic [PIX_W-1:0] s1_px_r;
  pix_meta_t        s1_meta_r;

  logic             in_acc;
  logic [PIX_W-1:0] rd_upper;
  logic [PIX_W-1:0] rd_middle;
  win_res_t         win_res;
  res_item_t        head;
  logic             q_not_empty;
  logic [FIFO_CW-1:0] q_level;
  logic [FIFO_CW-1:0] pending;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WID_W'(640);
      image_height_r <= HGT_W'(480);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[WID_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective dimensions, clamped to the supported range
  always_comb begin
    if (image_width_r < WID_W'(MIN_DIM)) begin
      w_eff = WID_W'(MIN_DIM);
    end else if (image_width_r > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width_r;
    end
    if (image_height_r < HGT_W'(MIN_DIM)) begin
      h_eff = HGT_W'(MIN_DIM);
    end else if (image_height_r > HGT_W'(MAX_HEIGHT)) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height_r;
    end
  end

  // admit a pixel only if its result is sure to find queue space
  assign pending   = q_level + FIFO_CW'(s1_v_r) + FIFO_CW'(win_res.busy);
  assign in_tready = (pending < FIFO_CW'(FIFO_DEPTH));
  assign in_acc    = in_tvalid && in_tready;

  // frame_start forces this pixel to (0,0)
  always_comb begin
    cur_col    = in_tuser ? '0 : col_count_r;
    cur_row    = in_tuser ? '0 : row_count_r;
    row_end    = ({1'b0, cur_col} + WID_W'(1)) >= w_eff;
    frame_last = row_end && (({1'b0, cur_row} + HGT_W'(1)) >= h_eff);
    if (row_end) begin
      col_count_nxt = '0;
      row_count_nxt = frame_last ? '0 : cur_row + ROW_W'(1);
    end else begin
      col_count_nxt = cur_col + COL_W'(1);
      row_count_nxt = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
      s1_v_r      <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
      if (in_acc) begin
        col_count_r <= col_count_nxt;
        row_count_r <= row_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r              <= in_tdata;
      s1_meta_r.row        <= cur_row;
      s1_meta_r.col        <= cur_col;
      s1_meta_r.frame_last <= frame_last;
      s1_meta_r.emit       <= (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
    end
  end

  // read at the column on accept; the row above shifts up on write-back
  lsh_line_store u_store (
    .clk       (clk),
    .rd_en     (in_acc),
    .rd_addr   (cur_col),
    .wr_en     (s1_v_r),
    .wr_addr   (s1_meta_r.col),
    .wr_upper  (rd_middle),
    .wr_middle (s1_px_r),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle)
  );

  lsh_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_v_r),
    .top_px   (rd_upper),
    .mid_px   (rd_middle),
    .bot_px   (s1_px_r),
    .meta_in  (s1_meta_r),
    .res      (win_res)
  );

  lsh_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (win_res.emit),
    .push_item (win_res.item),
    .pop       (out_tready),
    .not_empty (q_not_empty),
    .head      (head),
    .level     (q_level)
  );

  assign out_tvalid = q_not_empty;
  assign out_tdata  = {1'b0, head.out_col, head.out_row, head.out_pixel};
  assign out_tlast  = head.frame_end;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import lsh_pkg::*;

  localparam int QUIET_LIMIT  = 1000; // cycles with no transaction before giving up
  localparam int DRAIN_CYCLES = 8;    // pipeline drain plus margin
  localparam int ROW_LSB      = PIX_W;
  localparam int COL_LSB      = PIX_W + ROW_W;
  localparam int PAD_BIT      = PIX_W + ROW_W + COL_W;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  laplacian_sharpen_3x3 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Filter predictor state: line stores, 3x3 window, raster position, geometry
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] line_two_up [MAX_WIDTH];  // row r-2 at each column
  logic [PIX_W-1:0] line_one_up [MAX_WIDTH];  // row r-1 at each column
  logic [PIX_W-1:0] kernel_win [3][3];        // [top..bottom][oldest..newest]
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [WID_W-1:0] width_reg;
  logic [HGT_W-1:0] height_reg;

  res_item_t pending_sharpened[$];

  int  mismatch_count;
  int  quiet_cycles;
  bit  in_gaps;
  bit  out_stalls;

  initial begin
    foreach (line_two_up[i]) begin
      line_two_up[i] = '0;
      line_one_up[i] = '0;
    end
    foreach (kernel_win[a, b]) kernel_win[a][b] = '0;
    col_pos        = 0;
    row_pos        = 0;
    width_reg      = 640;
    height_reg     = 480;
    mismatch_count = 0;
    quiet_cycles   = 0;
    in_gaps        = 1'b1;
    out_stalls     = 1'b1;
  end

  task automatic flag_error(input string msg);
    mismatch_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic int unsigned eff_dim(input int unsigned v, input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // One accepted pixel: shift stores and window, queue the interior result.
  task automatic sharpen_step(input logic [PIX_W-1:0] px, input logic fs);
    int unsigned      w;
    int unsigned      h;
    int unsigned      r;
    int unsigned      c;
    int unsigned      idx;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic             row_end;
    logic             last_px;
    int               acc;
    int               v;
    res_item_t        want;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    r   = row_pos;
    c   = col_pos;
    idx = c % MAX_WIDTH;
    top = line_two_up[idx];
    mid = line_one_up[idx];
    line_two_up[idx] = mid;
    line_one_up[idx] = px;
    for (int i = 0; i < 3; i++) begin
      kernel_win[i][0] = kernel_win[i][1];
      kernel_win[i][1] = kernel_win[i][2];
    end
    kernel_win[0][2] = top;
    kernel_win[1][2] = mid;
    kernel_win[2][2] = px;
    row_end = (c + 1 >= w);
    last_px = row_end && (r + 1 >= h);
    if (r >= 2 && c >= 2) begin
      acc = 0;
      foreach (kernel_win[a, b]) acc += int'(kernel_win[a][b]);
      v = 9 * int'(kernel_win[1][1]) - acc;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      want.out_pixel = PIX_W'(v);
      want.out_row   = ROW_W'(r - 1);
      want.out_col   = COL_W'(c - 1);
      want.frame_end = last_px;
      pending_sharpened.push_back(want);
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = last_px ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------
  // Valid stays high across back-to-back transactions; it is only lowered
  // when a gap is drawn or the stream pauses.
  task automatic push_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int gap;
    gap = in_gaps ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= fs;
    do @(posedge clk); while (!in_tready);
    sharpen_step(px, fs);
  endtask

  // Stop the stream, wait for every expected result, then let the pipe empty.
  task automatic quiesce();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_sharpened.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_IMAGE_WIDTH) width_reg = val[WID_W-1:0];
    else height_reg = val[HGT_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h);
    quiesce();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
  endtask

  function automatic logic [PIX_W-1:0] draw_pixel();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // 3x3 frame: one center value surrounded by one neighbor value
  task automatic send_window(input logic [PIX_W-1:0] ctr, input logic [PIX_W-1:0] nbr,
                             input logic fs);
    for (int i = 0; i < 9; i++) push_pixel((i == 4) ? ctr : nbr, fs && (i == 0));
  endtask

  task automatic send_random_pixels(input int n, input bit start_frame);
    for (int i = 0; i < n; i++) push_pixel(draw_pixel(), start_frame && (i == 0));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall per transaction, field-by-field compare
  // ---------------------------------------------------------------------------
  initial begin : out_ready_gen
    int n;
    @(posedge rst_n);
    forever begin
      n = out_stalls ? $urandom_range(0, 7) : 0;
      @(negedge clk);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin : result_check
    res_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sharpened.size() == 0) begin
        flag_error($sformatf("unexpected result tdata=%h tlast=%b", out_tdata, out_tlast));
      end else begin
        want = pending_sharpened.pop_front();
        if (out_tdata[PIX_W-1:0] !== want.out_pixel)
          flag_error($sformatf("out_pixel got %0d want %0d (row %0d col %0d)",
                               out_tdata[PIX_W-1:0], want.out_pixel, want.out_row,
                               want.out_col));
        if (out_tdata[ROW_LSB +: ROW_W] !== want.out_row)
          flag_error($sformatf("out_row got %0d want %0d",
                               out_tdata[ROW_LSB +: ROW_W], want.out_row));
        if (out_tdata[COL_LSB +: COL_W] !== want.out_col)
          flag_error($sformatf("out_col got %0d want %0d",
                               out_tdata[COL_LSB +: COL_W], want.out_col));
        if (out_tlast !== want.frame_end)
          flag_error($sformatf("frame_end got %b want %b (row %0d col %0d)",
                               out_tlast, want.frame_end, want.out_row, want.out_col));
        if (out_tdata[PAD_BIT] !== 1'b0)
          flag_error("tdata pad bit not zero");
      end
    end
  end

  // Watchdog: no transaction on any channel for too long ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Smallest image: saturation high and low, frame wrap with no frame_start,
  // and a frame_start that cuts into a frame.
  task automatic test_directed_windows();
    set_geometry(3, 3);
    send_window(8'hFF, 8'h00, 1'b1);
    send_window(8'h00, 8'hFF, 1'b0);
    push_pixel(8'h5A, 1'b1);
    push_pixel(8'hA5, 1'b0);
    send_window(8'h81, 8'h7E, 1'b1);
  endtask

  // Width and height below the minimum clamp up to three.
  task automatic test_dim_clamps();
    set_geometry(0, 2);
    send_random_pixels(18, 1'b1);
    set_geometry(1, 0);
    send_random_pixels(18, 1'b1);
    set_geometry(2, 1);
    send_random_pixels(18, 1'b1);
  endtask

  // Width lowered while the position sits past the new row end.
  task automatic test_width_drop_mid_row();
    set_geometry(10, 6);
    send_random_pixels(25, 1'b1);
    quiesce();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(4));
    send_random_pixels(30, 1'b0);
    quiesce();
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    send_random_pixels(20, 1'b0);
  endtask

  // Small random geometries, mostly whole frames, with stray frame_start
  // pulses and truncated frames mixed in.
  task automatic test_random_frames();
    int          sent;
    int unsigned w_val;
    int unsigned h_val;
    int unsigned area;
    int          n;
    int          sel;
    logic        fs;
    sent = 0;
    while (sent < 800) begin
      sel   = $urandom_range(0, 9);
      w_val = (sel == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      h_val = (sel == 1) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      set_geometry(w_val, h_val);
      in_gaps    = ($urandom_range(0, 3) != 0);
      out_stalls = ($urandom_range(0, 3) != 0);
      area = eff_dim(w_val, MAX_WIDTH) * eff_dim(h_val, MAX_HEIGHT);
      n    = $urandom_range(1, 3) * area + $urandom_range(0, 2 * eff_dim(w_val, MAX_WIDTH));
      for (int i = 0; i < n; i++) begin
        // phase always opens on a frame start: the width may have grown
        if (i == 0) fs = 1'b1;
        else if (i % area == 0) fs = $urandom_range(0, 1);
        else fs = ($urandom_range(0, 39) == 0);
        push_pixel(draw_pixel(), fs);
      end
      sent += n;
    end
    in_gaps    = 1'b1;
    out_stalls = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_windows();
    test_dim_clamps();
    test_width_drop_mid_row();
    test_random_frames();
    quiesce();
    repeat (20) @(posedge clk);
    if (pending_sharpened.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", pending_sharpened.size()));
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
